// File: hdl/smi_pkg.sv
`timescale 1ns / 1ps

package smi_pkg;

    localparam int LIST_DEPTH = 64;
    localparam int IDX_W      = $clog2(LIST_DEPTH);
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

    localparam logic [1:0] MODE_LOAD_A  = 2'd0;
    localparam logic [1:0] MODE_LOAD_B  = 2'd1;
    localparam logic [1:0] MODE_COMPUTE = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] match_value;
        logic               last_match;
        logic               empty_result;
        logic               overflow_seen;
    } t_out;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_START,
        OP_SORT_CHK,
        OP_KEY_RD,
        OP_KEY_GET,
        OP_PREV_RD,
        OP_SORT_CMP,
        OP_PUT,
        OP_MERGE_RD,
        OP_MERGE_CMP,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic sel_b;
    } t_cmd;

    typedef struct packed {
        logic i_lt_n;
        logic gt;
        logic j_one;
        logic merge_go;
    } t_stat;

endpackage

// File: hdl/smi_ctrl.sv
`timescale 1ns / 1ps

module smi_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_mode,
    input  smi_pkg::t_stat    i_stat,
    output smi_pkg::t_cmd     o_cmd,
    output logic              o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_CHK,
        S_KEY_RD,
        S_KEY_GET,
        S_PREV_RD,
        S_SORT_CMP,
        S_PUT,
        S_MERGE_RD,
        S_MERGE_CMP,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_sel_b;
    logic   accept;

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && !o_busy;

    always_comb begin
        o_cmd.sel_b = r_sel_b;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_mode == smi_pkg::MODE_LOAD_A ||
                               i_mode == smi_pkg::MODE_LOAD_B)) begin
                    o_cmd.op = smi_pkg::OP_LOAD;
                end else if (accept && i_mode == smi_pkg::MODE_COMPUTE) begin
                    o_cmd.op = smi_pkg::OP_START;
                end else begin
                    o_cmd.op = smi_pkg::OP_NONE;
                end
            end
            S_SORT_CHK:  o_cmd.op = smi_pkg::OP_SORT_CHK;
            S_KEY_RD:    o_cmd.op = smi_pkg::OP_KEY_RD;
            S_KEY_GET:   o_cmd.op = smi_pkg::OP_KEY_GET;
            S_PREV_RD:   o_cmd.op = smi_pkg::OP_PREV_RD;
            S_SORT_CMP:  o_cmd.op = smi_pkg::OP_SORT_CMP;
            S_PUT:       o_cmd.op = smi_pkg::OP_PUT;
            S_MERGE_RD:  o_cmd.op = smi_pkg::OP_MERGE_RD;
            S_MERGE_CMP: o_cmd.op = smi_pkg::OP_MERGE_CMP;
            S_FINISH:    o_cmd.op = smi_pkg::OP_FINISH;
            default:     o_cmd.op = smi_pkg::OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel_b <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_mode == smi_pkg::MODE_COMPUTE) begin
                        r_sel_b <= 1'b0;
                        r_state <= S_SORT_CHK;
                    end
                end
                S_SORT_CHK: begin
                    if (i_stat.i_lt_n) begin
                        r_state <= S_KEY_RD;
                    end else if (!r_sel_b) begin
                        r_sel_b <= 1'b1;
                    end else begin
                        r_state <= S_MERGE_RD;
                    end
                end
                S_KEY_RD:  r_state <= S_KEY_GET;
                S_KEY_GET: r_state <= S_PREV_RD;
                S_PREV_RD: r_state <= S_SORT_CMP;
                S_SORT_CMP: begin
                    if (!i_stat.gt) begin
                        r_state <= S_SORT_CHK;
                    end else if (i_stat.j_one) begin
                        r_state <= S_PUT;
                    end else begin
                        r_state <= S_PREV_RD;
                    end
                end
                S_PUT: r_state <= S_SORT_CHK;
                S_MERGE_RD: begin
                    r_state <= i_stat.merge_go ? S_MERGE_CMP : S_FINISH;
                end
                S_MERGE_CMP: r_state <= S_MERGE_RD;
                S_FINISH:    r_state <= S_IDLE;
                default:     r_state <= S_IDLE;
            endcase
        end
    end

    // sort scan must have a predecessor to compare against
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PREV_RD |-> $past(r_state == S_KEY_GET || r_state == S_SORT_CMP))
        else $error("prev read without key");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_FINISH |=> r_state == S_IDLE)
        else $error("finish did not return to idle");

endmodule

// File: hdl/smi_dp.sv
`timescale 1ns / 1ps

module smi_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  smi_pkg::t_cmd   i_cmd,
    input  smi_pkg::t_in    i_item,
    output smi_pkg::t_stat  o_stat,
    output logic            o_strobe,
    output smi_pkg::t_out   o_result
);

    logic signed [31:0] mem_a [smi_pkg::LIST_DEPTH];
    logic signed [31:0] mem_b [smi_pkg::LIST_DEPTH];

    logic signed [31:0] r_rd_a, r_rd_b, r_key, r_pend_val;
    logic [smi_pkg::CNT_W-1:0] r_cnt_a, r_cnt_b, r_i, r_j, n_sel, j_dec;
    logic r_drop, r_pend_v;

    logic [smi_pkg::IDX_W-1:0] raddr_a, raddr_b, waddr;
    logic signed [31:0] rd_sel, wdata;
    logic we_a, we_b, a_full, b_full;

    assign a_full = (r_cnt_a >= smi_pkg::CNT_W'(smi_pkg::LIST_DEPTH));
    assign b_full = (r_cnt_b >= smi_pkg::CNT_W'(smi_pkg::LIST_DEPTH));
    assign n_sel  = i_cmd.sel_b ? r_cnt_b : r_cnt_a;
    assign rd_sel = i_cmd.sel_b ? r_rd_b : r_rd_a;
    assign j_dec  = r_j - smi_pkg::CNT_W'(1);

    assign o_stat.i_lt_n   = (r_i < n_sel);
    assign o_stat.gt       = (rd_sel > r_key);
    assign o_stat.j_one    = (r_j == smi_pkg::CNT_W'(1));
    assign o_stat.merge_go = (r_i < r_cnt_a) && (r_j < r_cnt_b);

    always_comb begin
        raddr_a = r_i[smi_pkg::IDX_W-1:0];
        raddr_b = r_i[smi_pkg::IDX_W-1:0];
        if (i_cmd.op == smi_pkg::OP_PREV_RD) begin
            raddr_a = j_dec[smi_pkg::IDX_W-1:0];
            raddr_b = j_dec[smi_pkg::IDX_W-1:0];
        end else if (i_cmd.op == smi_pkg::OP_MERGE_RD) begin
            raddr_b = r_j[smi_pkg::IDX_W-1:0];
        end
    end

    always_comb begin
        we_a  = 1'b0;
        we_b  = 1'b0;
        waddr = r_j[smi_pkg::IDX_W-1:0];
        wdata = r_key;
        unique case (i_cmd.op)
            smi_pkg::OP_LOAD: begin
                wdata = i_item.value;
                if (i_item.mode == smi_pkg::MODE_LOAD_A) begin
                    waddr = r_cnt_a[smi_pkg::IDX_W-1:0];
                    we_a  = !a_full;
                end else begin
                    waddr = r_cnt_b[smi_pkg::IDX_W-1:0];
                    we_b  = !b_full;
                end
            end
            smi_pkg::OP_SORT_CMP, smi_pkg::OP_PUT: begin
                if (i_cmd.op == smi_pkg::OP_SORT_CMP && o_stat.gt) begin
                    wdata = rd_sel;
                end
                we_a = !i_cmd.sel_b;
                we_b = i_cmd.sel_b;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we_a) mem_a[waddr] <= wdata;
        if (we_b) mem_b[waddr] <= wdata;
        r_rd_a <= mem_a[raddr_a];
        r_rd_b <= mem_b[raddr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a  <= '0;
            r_cnt_b  <= '0;
            r_drop   <= 1'b0;
            r_pend_v <= 1'b0;
            o_strobe <= 1'b0;
            r_i      <= '0;
            r_j      <= '0;
        end else begin
            o_strobe <= 1'b0;
            unique case (i_cmd.op)
                smi_pkg::OP_LOAD: begin
                    if (i_item.mode == smi_pkg::MODE_LOAD_A) begin
                        if (a_full) r_drop <= 1'b1;
                        else        r_cnt_a <= r_cnt_a + smi_pkg::CNT_W'(1);
                    end else begin
                        if (b_full) r_drop <= 1'b1;
                        else        r_cnt_b <= r_cnt_b + smi_pkg::CNT_W'(1);
                    end
                end
                smi_pkg::OP_START: begin
                    r_i      <= smi_pkg::CNT_W'(1);
                    r_pend_v <= 1'b0;
                end
                smi_pkg::OP_SORT_CHK: begin
                    if (!o_stat.i_lt_n) begin
                        r_i <= i_cmd.sel_b ? '0 : smi_pkg::CNT_W'(1);
                        r_j <= '0;
                    end
                end
                smi_pkg::OP_KEY_GET: begin
                    r_key <= rd_sel;
                    r_j   <= r_i;
                end
                smi_pkg::OP_SORT_CMP: begin
                    if (o_stat.gt) r_j <= j_dec;
                    else           r_i <= r_i + smi_pkg::CNT_W'(1);
                end
                smi_pkg::OP_PUT: r_i <= r_i + smi_pkg::CNT_W'(1);
                smi_pkg::OP_MERGE_CMP: begin
                    if (r_rd_a > r_rd_b) begin
                        r_j <= r_j + smi_pkg::CNT_W'(1);
                    end else if (r_rd_b > r_rd_a) begin
                        r_i <= r_i + smi_pkg::CNT_W'(1);
                    end else begin
                        r_i <= r_i + smi_pkg::CNT_W'(1);
                        r_j <= r_j + smi_pkg::CNT_W'(1);
                        // hold one match back so the final one can carry last
                        if (r_pend_v) begin
                            o_strobe                <= 1'b1;
                            o_result.match_value    <= r_pend_val;
                            o_result.last_match     <= 1'b0;
                            o_result.empty_result   <= 1'b0;
                            o_result.overflow_seen  <= r_drop;
                        end
                        r_pend_v   <= 1'b1;
                        r_pend_val <= r_rd_a;
                    end
                end
                smi_pkg::OP_FINISH: begin
                    o_strobe               <= 1'b1;
                    o_result.match_value   <= r_pend_v ? r_pend_val : '0;
                    o_result.last_match    <= 1'b1;
                    o_result.empty_result  <= !r_pend_v;
                    o_result.overflow_seen <= r_drop;
                    r_cnt_a  <= '0;
                    r_cnt_b  <= '0;
                    r_drop   <= 1'b0;
                    r_pend_v <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_cmd.op == smi_pkg::OP_MERGE_CMP ||
                           i_cmd.op == smi_pkg::OP_FINISH))
        else $error("result outside merge");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt_a <= smi_pkg::CNT_W'(smi_pkg::LIST_DEPTH) &&
        r_cnt_b <= smi_pkg::CNT_W'(smi_pkg::LIST_DEPTH))
        else $error("list count past capacity");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == smi_pkg::OP_FINISH |=> r_cnt_a == '0 && r_cnt_b == '0 && !r_drop)
        else $error("lists not cleared after job");

endmodule

// File: hdl/sorted_multiset_intersection_unit.sv
`timescale 1ns / 1ps

// channel   | ports                        | transfer when
// ----------+------------------------------+------------------------------
// item in   | i_start, i_item, o_busy      | i_start high and o_busy low
// result    | o_strobe, o_result           | every cycle o_strobe is high
//
// Loads (mode 0/1) leave o_busy low; a new item may follow immediately.
// A compute item holds o_busy for an insertion sort of each list: a check,
// key read and key capture per element past the first, a predecessor read
// and compare per step back, a put when the key reaches the front, and one
// closing check per list; then merge read/compare steps, closing read, finish.
// Results appear during the walk and at the finish; the receiver cannot stall.
// Reset is synchronous, active low; list contents are not cleared.
module sorted_multiset_intersection_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  smi_pkg::t_in   i_item,
    output logic           o_busy,
    output logic           o_strobe,
    output smi_pkg::t_out  o_result
);

    smi_pkg::t_cmd  cmd;
    smi_pkg::t_stat stat;

    // sequencer: load / sort / merge / finish
    smi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_item.mode),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    // two list memories, counters, compare and result registers
    smi_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
